[design/skbs_pkg.sv]
// Shared types, sizes and the key normalisation function for the sorted key
// binary search block. No dependencies; skbs_front, skbs_level and the top level use it.
package skbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_CHARS   = 8;
  localparam int KEY_W       = 64;
  localparam int INDEX_W     = 8;
  localparam int POS_W       = 8;
  localparam int CFG_W       = 9;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int LEVELS      = COUNT_W;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [KEY_W-1:0]   key_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    logic               vld;
    op_t                op;
    logic [INDEX_W-1:0] index;
    key_t               key;
    count_t             lo;
    count_t             hi_ex;
    logic               done;
    logic               found;
    pos_t               position;
  } item_t;

  // A sign ends at its first zero byte and keeps at most KEY_CHARS bytes.
  function automatic key_t normalize_key(key_t k);
    key_t res;
    logic live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_CHARS || k[63-8*b -: 8] == 8'h00) live = 1'b0;
      if (live) res[63-8*b -: 8] = k[63-8*b -: 8];
    end
    return res;
  endfunction

endpackage

[design/skbs_req_if.sv]
// Request channel of the sorted key binary search block: write or search items.
// Uses no package.
interface skbs_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [63:0] key;

  modport source(output valid, operation, entry_index, key, input ready);
  modport sink(input valid, operation, entry_index, key, output ready);
endinterface

[design/skbs_res_if.sv]
// Result channel of the sorted key binary search block: one item per search.
// Uses no package.
interface skbs_res_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] position;

  modport source(output valid, found, position, input ready);
  modport sink(input valid, found, position, output ready);
endinterface

[design/skbs_cfg_if.sv]
// Configuration write channel carrying the entry count register value.
// Uses no package.
interface skbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[design/skbs_front.sv]
// Entry stage: registers an accepted item, normalises its key and sets up the
// initial search range. Depends on skbs_pkg and skbs_req_if.
module skbs_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [skbs_pkg::CFG_W-1:0] entry_count,
  skbs_req_if.sink                   req,
  output skbs_pkg::item_t            item_out
);

  skbs_pkg::item_t   item_next;
  skbs_pkg::count_t  count;

  assign req.ready = advance;

  always_comb begin
    if (32'(entry_count) > 32'(skbs_pkg::TABLE_DEPTH)) begin
      count = skbs_pkg::count_t'(skbs_pkg::TABLE_DEPTH);
    end else begin
      count = skbs_pkg::count_t'(entry_count);
    end
    item_next.vld      = req.valid;
    item_next.op       = skbs_pkg::op_t'(req.operation);
    item_next.index    = req.entry_index;
    item_next.key      = skbs_pkg::normalize_key(req.key);
    item_next.lo       = '0;
    item_next.hi_ex    = count;
    item_next.done     = 1'b0;
    item_next.found    = 1'b0;
    item_next.position = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.vld <= 1'b0;
    end else if (advance) begin
      item_out <= item_next;
    end
  end

endmodule

[design/skbs_level.sv]
// One level of the search pipeline: a private copy of the key table, a
// registered probe read and a compare stage. Depends on skbs_pkg.
module skbs_level (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  skbs_pkg::item_t item_in,
  output skbs_pkg::item_t item_out
);

  logic [skbs_pkg::KEY_W-1:0] mem [skbs_pkg::TABLE_DEPTH];

  skbs_pkg::item_t  a_item;
  skbs_pkg::count_t a_mid;
  logic             a_probe;
  skbs_pkg::key_t   rd_key;

  skbs_pkg::count_t span;
  skbs_pkg::count_t mid;
  logic             probe;
  logic             store;
  skbs_pkg::item_t  item_next;

  always_comb begin
    probe = item_in.vld && item_in.op == skbs_pkg::OP_SEARCH && !item_in.done &&
            item_in.lo < item_in.hi_ex;
    store = item_in.vld && item_in.op == skbs_pkg::OP_WRITE &&
            32'(item_in.index) < 32'(skbs_pkg::TABLE_DEPTH);
    span  = item_in.hi_ex - item_in.lo - skbs_pkg::count_t'(1);
    mid   = item_in.lo + (span >> 1);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (store) mem[skbs_pkg::addr_t'(item_in.index)] <= item_in.key;
      if (probe) rd_key <= mem[mid[skbs_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_item.vld <= 1'b0;
    end else if (advance) begin
      a_item  <= item_in;
      a_mid   <= mid;
      a_probe <= probe;
    end
  end

  always_comb begin
    item_next = a_item;
    if (a_item.vld && a_probe) begin
      if (rd_key == a_item.key) begin
        item_next.done     = 1'b1;
        item_next.found    = 1'b1;
        item_next.position = skbs_pkg::pos_t'(a_mid);
      end else if (rd_key < a_item.key) begin
        item_next.lo = a_mid + skbs_pkg::count_t'(1);
      end else begin
        item_next.hi_ex = a_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.vld <= 1'b0;
    end else if (advance) begin
      item_out <= item_next;
    end
  end

endmodule

[design/sorted_key_binary_search.sv]
// Top level of the sorted key binary search block. Depends on skbs_pkg, the
// three channel interfaces, skbs_front and skbs_level.
//
// Every item, write or search, passes through an entry stage and then one
// level per possible probe (nine for a 256-entry table), each level holding
// its own copy of the key table, reading it one cycle and comparing the next.
// The block takes one item per cycle, but the whole pipeline holds while a
// result waits unaccepted. A search result comes from the last level, and
// writes give no result. A write reaches each table copy in order with the
// searches around it, so a search sees every earlier write and none later.
// The entry count register is written through the configuration channel,
// which is always ready; keys must be loaded in ascending order.
module sorted_key_binary_search (
  input logic      clk,
  input logic      rst,
  skbs_req_if.sink req,
  skbs_res_if.source res,
  skbs_cfg_if.sink cfg
);

  logic [skbs_pkg::CFG_W-1:0] entry_count;
  logic                       advance;
  skbs_pkg::item_t            chain [skbs_pkg::LEVELS+1];
  skbs_pkg::item_t            last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid) begin
      entry_count <= cfg.data;
    end
  end

  assign last         = chain[skbs_pkg::LEVELS];
  assign res.valid    = last.vld && last.op == skbs_pkg::OP_SEARCH;
  assign res.found    = last.found;
  assign res.position = last.position;
  assign advance      = !res.valid || res.ready;

  skbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .entry_count (entry_count),
    .req         (req),
    .item_out    (chain[0])
  );

  for (genvar i = 0; i < skbs_pkg::LEVELS; i++) begin : g_level
    skbs_level u_level (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .item_in  (chain[i]),
      .item_out (chain[i+1])
    );
  end

endmodule

[design/skbs_checker.sv]
// Port-level checks for the sorted key binary search block, bound to its top
// level. Uses no package.
module skbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_found,
  input logic [7:0] res_position
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_position))
    else $error("result item changed while stalled");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_position == 8'd0)
    else $error("miss reported with a non-zero position");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request refused with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result item shown straight after reset");

endmodule

bind sorted_key_binary_search skbs_checker u_skbs_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_found    (res.found),
  .res_position (res.position)
);

[tb/tb_sorted_key_binary_search.sv]
// Self-checking testbench for the sorted key binary search block: loads key tables,
// runs searches under random idling and back-pressure, and checks every result.
// Depends on skbs_pkg, the three channel interfaces and sorted_key_binary_search.
`timescale 1ns / 1ps

module tb_sorted_key_binary_search;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 25;
  localparam int TAIL_CYCLES   = 40;

  typedef struct {
    logic           found;
    skbs_pkg::pos_t position;
  } lookup_t;

  logic clk = 1'b0;
  logic rst;

  skbs_req_if req_ch ();
  skbs_res_if res_ch ();
  skbs_cfg_if cfg_ch ();

  sorted_key_binary_search i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  skbs_pkg::key_t             model_keys [skbs_pkg::TABLE_DEPTH];
  bit                         slot_written [skbs_pkg::TABLE_DEPTH];
  logic [skbs_pkg::CFG_W-1:0] model_count = '0;
  lookup_t                    pending_lookups [$];
  int                         mismatch_count = 0;
  int                         writes_sent = 0;
  int                         searches_sent = 0;
  int                         hits_sent = 0;
  int                         counts_used = 0;
  bit                         sender_idling = 1'b0;
  bit                         sink_idling = 1'b0;
  int                         sink_hold = 0;
  int                         quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A call sign ends at its first zero byte; everything after it is dropped.
  function automatic skbs_pkg::key_t strip_key(skbs_pkg::key_t raw);
    skbs_pkg::key_t k;
    k = '0;
    for (int b = 7; b >= 0; b--) begin
      if (raw[8*b +: 8] == 8'h00) break;
      k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

  function automatic skbs_pkg::key_t make_sign();
    skbs_pkg::key_t k;
    int             len;
    k = '0;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    len = $urandom_range(1, 8);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 3) == 0) k[63-8*b -: 8] = 8'h30 + 8'($urandom_range(0, 9));
      else k[63-8*b -: 8] = 8'h41 + 8'($urandom_range(0, 25));
    end
    return k;
  endfunction

  function automatic skbs_pkg::key_t add_tail(skbs_pkg::key_t k);
    skbs_pkg::key_t r;
    bit             past;
    r    = k;
    past = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      if (past) r[8*b +: 8] = 8'($urandom);
      else if (k[8*b +: 8] == 8'h00) past = 1'b1;
    end
    return r;
  endfunction

  function automatic skbs_pkg::key_t vary_key(skbs_pkg::key_t k);
    return ($urandom_range(0, 2) == 0) ? add_tail(k) : k;
  endfunction

  function automatic int table_span();
    return (model_count > skbs_pkg::TABLE_DEPTH) ? skbs_pkg::TABLE_DEPTH : int'(model_count);
  endfunction

  function automatic bit all_written(int n);
    for (int i = 0; i < n; i++) begin
      if (!slot_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic lookup_t lookup_key(skbs_pkg::key_t raw);
    lookup_t        r;
    skbs_pkg::key_t k;
    int             lo;
    int             hi;
    int             mid;
    k          = strip_key(raw);
    r.found    = 1'b0;
    r.position = '0;
    lo         = 0;
    hi         = table_span() - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_keys[mid] == k) begin
        r.found    = 1'b1;
        r.position = skbs_pkg::pos_t'(mid);
        break;
      end else if (model_keys[mid] < k) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want_v);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ns mismatch: %s, got %0d, expected %0d", $time, what, got, want_v);
  endtask

  task automatic send_item(skbs_pkg::op_t op, logic [skbs_pkg::INDEX_W-1:0] idx,
                           skbs_pkg::key_t raw);
    lookup_t outcome;
    if (sender_idling && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.entry_index <= idx;
    req_ch.key         <= raw;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == skbs_pkg::OP_WRITE) begin
      model_keys[idx]   = strip_key(raw);
      slot_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      outcome = lookup_key(raw);
      pending_lookups.push_back(outcome);
      searches_sent++;
      if (outcome.found) hits_sent++;
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  task automatic write_count(logic [skbs_pkg::CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_count = value;
    counts_used++;
  endtask

  task automatic load_table(int n);
    skbs_pkg::key_t sorted_keys [skbs_pkg::TABLE_DEPTH];
    int             order [skbs_pkg::TABLE_DEPTH];
    skbs_pkg::key_t tmp;
    int             j;
    int             pick;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) sorted_keys[i] = sorted_keys[i-1];
      else sorted_keys[i] = strip_key(make_sign());
      order[i] = i;
    end
    for (int i = 1; i < n; i++) begin
      tmp = sorted_keys[i];
      j   = i - 1;
      while (j >= 0 && sorted_keys[j] > tmp) begin
        sorted_keys[j+1] = sorted_keys[j];
        j--;
      end
      sorted_keys[j+1] = tmp;
    end
    for (int i = n - 1; i > 0; i--) begin
      pick        = $urandom_range(0, i);
      j           = order[i];
      order[i]    = order[pick];
      order[pick] = j;
    end
    for (int i = 0; i < n; i++)
      send_item(skbs_pkg::OP_WRITE, skbs_pkg::INDEX_W'(order[i]),
                vary_key(sorted_keys[order[i]]));
  endtask

  task automatic set_up_table(logic [skbs_pkg::CFG_W-1:0] count, bit reload);
    write_count(count);
    if (reload || !all_written(table_span())) load_table(table_span());
  endtask

  // Mostly searches, about half of all items for stored signs, with a little noise that may break the order.
  task automatic random_traffic(int n_items);
    int span;
    int slot;
    int choice;
    span = table_span();
    repeat (n_items) begin
      choice = $urandom_range(0, 19);
      slot   = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if (choice == 0 && span > 0) begin
        send_item(skbs_pkg::OP_WRITE, skbs_pkg::INDEX_W'(slot), make_sign());
      end else if (choice == 1 && span > 0) begin
        send_item(skbs_pkg::OP_WRITE, skbs_pkg::INDEX_W'(slot), add_tail(model_keys[slot]));
      end else if (choice == 2 && span < skbs_pkg::TABLE_DEPTH) begin
        send_item(skbs_pkg::OP_WRITE,
                  skbs_pkg::INDEX_W'($urandom_range(span, skbs_pkg::TABLE_DEPTH - 1)),
                  make_sign());
      end else if (choice < 13 && span > 0) begin
        send_item(skbs_pkg::OP_SEARCH, skbs_pkg::INDEX_W'($urandom),
                  vary_key(model_keys[slot]));
      end else begin
        send_item(skbs_pkg::OP_SEARCH, skbs_pkg::INDEX_W'($urandom), make_sign());
      end
    end
  endtask

  task automatic test_empty_table();
    sender_idling = 1'b1;
    sink_idling   = 1'b1;
    write_count(skbs_pkg::CFG_W'(0));
    send_item(skbs_pkg::OP_SEARCH, 8'h00, 64'h0);
    send_item(skbs_pkg::OP_SEARCH, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_directed_lookups();
    write_count(skbs_pkg::CFG_W'(6));
    send_item(skbs_pkg::OP_WRITE, 8'd0, 64'h00FF_1234_5678_9ABC);
    send_item(skbs_pkg::OP_WRITE, 8'd1, 64'h4100_0000_0000_0000);
    send_item(skbs_pkg::OP_WRITE, 8'd2, 64'h4142_0000_0000_0000);
    send_item(skbs_pkg::OP_WRITE, 8'd3, 64'h4142_0099_AA55_0001);
    send_item(skbs_pkg::OP_WRITE, 8'd4, 64'h5A5A_5A5A_5A5A_5A5A);
    send_item(skbs_pkg::OP_WRITE, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(skbs_pkg::OP_SEARCH, 8'h00, 64'h0000_0000_0000_0000);
    send_item(skbs_pkg::OP_SEARCH, 8'h55, 64'h4100_0000_0000_0000);
    send_item(skbs_pkg::OP_SEARCH, 8'hAA, 64'h4142_0000_0000_0000);
    send_item(skbs_pkg::OP_SEARCH, 8'h0F, 64'h4142_00FF_FFFF_FFFF);
    send_item(skbs_pkg::OP_SEARCH, 8'hF0, 64'h5A5A_5A5A_5A5A_5A5A);
    send_item(skbs_pkg::OP_SEARCH, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(skbs_pkg::OP_SEARCH, 8'h01, 64'h4200_0000_0000_0000);
  endtask

  task automatic test_small_tables();
    set_up_table(skbs_pkg::CFG_W'(1), 1'b1);
    random_traffic(20);
    sender_idling = 1'b0;
    set_up_table(skbs_pkg::CFG_W'(2), 1'b1);
    random_traffic(20);
  endtask

  task automatic test_full_table();
    sender_idling = 1'b1;
    sink_idling   = 1'b1;
    set_up_table(skbs_pkg::CFG_W'(skbs_pkg::TABLE_DEPTH), 1'b1);
    random_traffic(60);
    set_up_table(skbs_pkg::CFG_W'(skbs_pkg::TABLE_DEPTH + 1), 1'b0);
    random_traffic(30);
    set_up_table(skbs_pkg::CFG_W'(511), 1'b0);
    random_traffic(30);
  endtask

  task automatic test_random_sizes();
    repeat (4) begin
      sender_idling = 1'($urandom_range(0, 1));
      sink_idling   = 1'($urandom_range(0, 1));
      set_up_table(skbs_pkg::CFG_W'($urandom_range(3, 40)), 1'b1);
      random_traffic(30);
    end
  endtask

  task automatic test_result_backpressure();
    sender_idling = 1'b0;
    sink_idling   = 1'b0;
    set_up_table(skbs_pkg::CFG_W'($urandom_range(8, 32)), 1'b1);
    sink_hold = 300;
    random_traffic(80);
  endtask

  task automatic test_drain_pause();
    sender_idling = 1'b1;
    sink_idling   = 1'b1;
    random_traffic(30);
    wait_drained();
    random_traffic(30);
  endtask

  task automatic test_steady_stream();
    sender_idling = 1'b0;
    sink_idling   = 1'b0;
    set_up_table(skbs_pkg::CFG_W'($urandom_range(10, 60)), 1'b1);
    random_traffic(80);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        res_ch.ready <= 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    lookup_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with no search outstanding", res_ch.position, 0);
      end else begin
        want = pending_lookups.pop_front();
        if (res_ch.found !== want.found)
          report_mismatch("found flag", res_ch.found, want.found);
        if (res_ch.position !== want.position)
          report_mismatch("position", res_ch.position, want.position);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles with no item accepted.", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= skbs_pkg::OP_WRITE;
    req_ch.entry_index <= '0;
    req_ch.key         <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed_lookups();
    test_small_tables();
    test_full_table();
    test_random_sizes();
    test_result_backpressure();
    test_drain_pause();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d key writes and %0d searches, %0d of them expected to hit,",
             writes_sent, searches_sent, hits_sent);
    $display("across %0d entry count settings from empty to beyond full.", counts_used);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches seen.", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
design/skbs_pkg.sv
design/skbs_req_if.sv
design/skbs_res_if.sv
design/skbs_cfg_if.sv
design/skbs_front.sv
design/skbs_level.sv
design/sorted_key_binary_search.sv
design/skbs_checker.sv
tb/tb_sorted_key_binary_search.sv
